>>> src/utf8ds_pkg.sv
// Package for the UTF-8 display sanitizer: request and result structs, the
// decoded-item descriptor, replacement character bytes and code point checks.
// Depends on nothing.
package utf8ds_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_req_t;

  // Output of one input byte: rep_cnt replacement characters, then raw_cnt raw bytes.
  typedef struct packed {
    logic [2:0]      rep_cnt;
    logic [2:0]      raw_cnt;
    logic [3:0][7:0] raw_bytes;
    logic            last;
  } desc_t;

  localparam logic [7:0] REP_BYTE0 = 8'hef;
  localparam logic [7:0] REP_BYTE1 = 8'hbf;
  localparam logic [7:0] REP_BYTE2 = 8'hbd;

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  function automatic logic is_unsafe(input logic [20:0] cp);
    return (cp < 21'h20) || (cp == 21'h7f) || (cp >= 21'h80 && cp <= 21'h9f) ||
           (cp == 21'h061c) || (cp == 21'h200e) || (cp == 21'h200f) ||
           (cp >= 21'h2028 && cp <= 21'h202e) ||
           (cp >= 21'h2066 && cp <= 21'h2069);
  endfunction

endpackage

>>> src/utf8_display_sanitizer_unit.sv
// UTF-8 display sanitizer, top level.
// Input channel: in_valid, in_stall and in_req carry one raw byte per request,
// with in_last marking the final byte of a string.
// Output channel: out_valid, out_stall and out_req carry one sanitized byte per
// request; run_last marks the last byte released by an input byte and
// string_end marks the final byte of the string.
// Each request enters an input register, is decoded against the open sequence
// into a descriptor of zero to twelve output bytes, and the serializer sends
// those bytes through the output register at one byte per cycle while out_stall is low.
// A request passes from the input register into the serializer, then to the output register.
// A request that releases at most one byte sustains one request per cycle while
// out_stall is low; one that releases more bytes holds the serializer until its
// last byte moves, since the output port moves a single byte per cycle. A request
// that only extends an open sequence releases nothing and is consumed without a descriptor.
// Reset closes any open sequence and empties all stages.
// While out_stall is high the output register holds its byte, and stall
// backs up through the serializer and the input register to in_stall.
// Depends on utf8ds_pkg, utf8ds_decoder and utf8ds_serializer.
module utf8_display_sanitizer_unit
  import utf8ds_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_req
);

  logic  desc_valid;
  logic  desc_take;
  desc_t desc;

  utf8ds_decoder u_decoder (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_take  (desc_take)
  );

  utf8ds_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_take  (desc_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_req    (out_req)
  );

endmodule

>>> src/utf8ds_decoder.sv
// Input register and sequence decoder of the UTF-8 display sanitizer.
// Turns each input byte into a descriptor of the bytes it releases.
// Depends on utf8ds_pkg.
module utf8ds_decoder
  import utf8ds_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  in_req_t in_req,
  output logic    desc_valid,
  output desc_t   desc,
  input  logic    desc_take
);

  logic            in_vld_r;
  in_req_t         in_r;
  logic [2:0]      exp_r;
  logic [2:0]      exp_nxt;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;
  logic [2:0][7:0] pend_r;
  logic [2:0][7:0] pend_nxt;

  logic [7:0]  b;
  logic        seq_open;
  logic        is_cont;
  logic        finishing;
  logic        f_open;
  logic        f_bad;
  logic [2:0]  f_exp;
  logic [2:0]  base_reps;
  logic [20:0] cp;
  logic        cp_ok;
  logic [1:0]  last_idx;
  logic        consume;
  desc_t       d;

  assign b         = in_r.in_byte;
  assign seq_open  = (exp_r != LEN_NONE);
  assign is_cont   = (b[7:6] == 2'b10);
  assign finishing = seq_open && is_cont && (({1'b0, cnt_r} + 3'd1) >= exp_r);
  assign f_open    = (b[7:6] == 2'b11) && (b[7:3] != 5'b11111);
  assign f_bad     = b[7] ? !f_open : ((b < 8'h20) || (b == 8'h7f));
  assign f_exp     = !b[5] ? LEN_TWO : (!b[4] ? LEN_THREE : LEN_FOUR);
  assign base_reps = seq_open ? {1'b0, cnt_r} : 3'd0;
  assign last_idx  = exp_r[1:0] - 2'd1;

  always_comb begin
    cp    = '0;
    cp_ok = 1'b0;
    unique case (exp_r)
      LEN_TWO: begin
        cp    = {10'd0, pend_r[0][4:0], b[5:0]};
        cp_ok = (cp >= 21'h80);
      end
      LEN_THREE: begin
        cp    = {5'd0, pend_r[0][3:0], pend_r[1][5:0], b[5:0]};
        cp_ok = (cp >= 21'h800) && !(cp >= 21'hd800 && cp <= 21'hdfff);
      end
      LEN_FOUR: begin
        cp    = {pend_r[0][2:0], pend_r[1][5:0], pend_r[2][5:0], b[5:0]};
        cp_ok = (cp >= 21'h10000) && (cp <= 21'h10ffff);
      end
      default: begin
        cp    = '0;
        cp_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    d           = '0;
    d.last      = in_r.in_last;
    exp_nxt     = exp_r;
    cnt_nxt     = cnt_r;
    pend_nxt    = pend_r;
    if (seq_open && is_cont) begin
      if (finishing) begin
        exp_nxt = LEN_NONE;
        cnt_nxt = 2'd0;
        if (!cp_ok) begin
          d.rep_cnt = exp_r;
        end else if (is_unsafe(cp)) begin
          d.rep_cnt = 3'd1;
        end else begin
          d.raw_cnt           = exp_r;
          d.raw_bytes[0]      = pend_r[0];
          d.raw_bytes[1]      = pend_r[1];
          d.raw_bytes[2]      = pend_r[2];
          d.raw_bytes[last_idx] = b;
        end
      end else begin
        pend_nxt[cnt_r] = b;
        cnt_nxt         = cnt_r + 2'd1;
      end
    end else begin
      d.rep_cnt = base_reps;
      exp_nxt   = LEN_NONE;
      cnt_nxt   = 2'd0;
      if (f_open) begin
        pend_nxt[0] = b;
        cnt_nxt     = 2'd1;
        exp_nxt     = f_exp;
      end else if (f_bad) begin
        d.rep_cnt = base_reps + 3'd1;
      end else begin
        d.raw_cnt      = 3'd1;
        d.raw_bytes[0] = b;
      end
    end
    if (in_r.in_last && (exp_nxt != LEN_NONE)) begin
      d.rep_cnt = d.rep_cnt + {1'b0, cnt_nxt};
      exp_nxt   = LEN_NONE;
      cnt_nxt   = 2'd0;
    end
  end

  assign desc       = d;
  assign desc_valid = in_vld_r && ((d.rep_cnt != 3'd0) || (d.raw_cnt != 3'd0));
  assign consume    = in_vld_r && (!desc_valid || desc_take);
  assign in_stall   = in_vld_r && !consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      exp_r    <= LEN_NONE;
      cnt_r    <= 2'd0;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (consume) begin
        in_vld_r <= 1'b0;
      end
      if (consume) begin
        exp_r <= exp_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_req;
    end
    if (consume) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

>>> src/utf8ds_serializer.sv
// Byte serializer of the UTF-8 display sanitizer: holds one descriptor and
// sends its bytes one per cycle, while out_stall is low, through the output register.
// Depends on utf8ds_pkg.
module utf8ds_serializer
  import utf8ds_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     desc_valid,
  input  desc_t    desc,
  output logic     desc_take,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_req
);

  logic            sd_vld_r;
  logic [2:0]      reps_r;
  logic [1:0]      phase_r;
  logic [2:0]      raw_cnt_r;
  logic [1:0]      raw_idx_r;
  logic [3:0][7:0] raw_r;
  logic            last_r;
  logic            out_vld_r;
  out_req_t        out_r;

  logic       move;
  logic       final_byte;
  logic [7:0] cur_byte;

  always_comb begin
    cur_byte = raw_r[raw_idx_r];
    if (reps_r != 3'd0) begin
      unique case (phase_r)
        PHASE_FIRST:  cur_byte = REP_BYTE0;
        PHASE_SECOND: cur_byte = REP_BYTE1;
        default:      cur_byte = REP_BYTE2;
      endcase
    end
  end

  assign final_byte = (reps_r != 3'd0)
                      ? ((reps_r == 3'd1) && (phase_r == PHASE_THIRD) && (raw_cnt_r == 3'd0))
                      : (({1'b0, raw_idx_r} + 3'd1) == raw_cnt_r);
  assign move       = sd_vld_r && (!out_vld_r || !out_stall);
  assign desc_take  = !sd_vld_r || (move && final_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (desc_take) begin
        sd_vld_r <= desc_valid;
      end
      if (move) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_take && desc_valid) begin
      reps_r    <= desc.rep_cnt;
      phase_r   <= PHASE_FIRST;
      raw_cnt_r <= desc.raw_cnt;
      raw_idx_r <= 2'd0;
      raw_r     <= desc.raw_bytes;
      last_r    <= desc.last;
    end else if (move) begin
      if (reps_r != 3'd0) begin
        if (phase_r == PHASE_THIRD) begin
          phase_r <= PHASE_FIRST;
          reps_r  <= reps_r - 3'd1;
        end else begin
          phase_r <= phase_r + 2'd1;
        end
      end else begin
        raw_idx_r <= raw_idx_r + 2'd1;
      end
    end
    if (move) begin
      out_r.out_byte   <= cur_byte;
      out_r.run_last   <= final_byte;
      out_r.string_end <= final_byte && last_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_req   = out_r;

endmodule

>>> sim/utf8_display_sanitizer_unit_tb.sv
// Self-checking testbench for utf8_display_sanitizer_unit: directed and random byte strings
// with random idling on both channels, checked byte by byte against a behavioral mirror.
// Depends on utf8ds_pkg and the utf8_display_sanitizer_unit RTL.
module utf8_display_sanitizer_unit_tb;
  import utf8ds_pkg::*;

  class sanitizer_mirror;
    logic [7:0] seq_bytes [3];
    logic [1:0] held_cnt;
    logic [2:0] seq_len;
    out_req_t   step_out [$];
    out_req_t   owed_bytes [$];
    int         errors;

    function new();
      held_cnt = 2'd0;
      seq_len  = LEN_NONE;
      errors   = 0;
    endfunction

    function void put(logic [7:0] b);
      out_req_t r;
      if (step_out.size() < 12) begin
        r.out_byte   = b;
        r.run_last   = 1'b0;
        r.string_end = 1'b0;
        step_out.push_back(r);
      end
    endfunction

    function void put_rep();
      put(REP_BYTE0);
      put(REP_BYTE1);
      put(REP_BYTE2);
    endfunction

    function bit hidden_on_display(logic [20:0] cp);
      return (cp < 21'h20) || (cp == 21'h7f) || (cp >= 21'h80 && cp <= 21'h9f) ||
             (cp == 21'h061c) || (cp == 21'h200e) || (cp == 21'h200f) ||
             (cp >= 21'h2028 && cp <= 21'h202e) || (cp >= 21'h2066 && cp <= 21'h2069);
    endfunction

    function void drop_held();
      for (int i = 0; i < held_cnt; i++) put_rep();
      held_cnt = 2'd0;
      seq_len  = LEN_NONE;
    endfunction

    function void close_seq(logic [7:0] b);
      logic [7:0]  s [4];
      logic [20:0] cp;
      bit          ok;
      int          n;
      n = seq_len;
      for (int i = 0; i < n - 1; i++) s[i] = seq_bytes[i];
      s[n-1] = b;
      case (seq_len)
        LEN_TWO: begin
          cp = {10'b0, s[0][4:0], s[1][5:0]};
          ok = cp >= 21'h80;
        end
        LEN_THREE: begin
          cp = {5'b0, s[0][3:0], s[1][5:0], s[2][5:0]};
          ok = cp >= 21'h800 && !(cp >= 21'hd800 && cp <= 21'hdfff);
        end
        default: begin
          cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
          ok = cp >= 21'h10000 && cp <= 21'h10ffff;
        end
      endcase
      if (!ok) begin
        for (int i = 0; i < n; i++) put_rep();
      end else if (hidden_on_display(cp)) begin
        put_rep();
      end else begin
        for (int i = 0; i < n; i++) put(s[i]);
      end
      held_cnt = 2'd0;
      seq_len  = LEN_NONE;
    endfunction

    function void open_fresh(logic [7:0] b);
      if (b < 8'h80) begin
        if (hidden_on_display({13'b0, b})) put_rep();
        else put(b);
      end else if (b < 8'hc0 || b >= 8'hf8) begin
        put_rep();
      end else begin
        seq_bytes[0] = b;
        held_cnt     = 2'd1;
        seq_len      = (b < 8'he0) ? LEN_TWO : (b < 8'hf0) ? LEN_THREE : LEN_FOUR;
      end
    endfunction

    function void take_byte(in_req_t r);
      out_req_t t;
      step_out.delete();
      if (seq_len != LEN_NONE) begin
        if (r.in_byte[7:6] == 2'b10) begin
          if (held_cnt + 1 >= seq_len) begin
            close_seq(r.in_byte);
          end else if (held_cnt < 3) begin
            seq_bytes[held_cnt] = r.in_byte;
            held_cnt++;
          end else begin
            drop_held();
            put_rep();
          end
        end else begin
          drop_held();
          open_fresh(r.in_byte);
        end
      end else begin
        open_fresh(r.in_byte);
      end
      if (r.in_last && seq_len != LEN_NONE) drop_held();
      if (step_out.size() > 0) begin
        t = step_out.pop_back();
        t.run_last   = 1'b1;
        t.string_end = r.in_last;
        step_out.push_back(t);
      end
      foreach (step_out[i]) owed_bytes.push_back(step_out[i]);
    endfunction

    function void match_output(out_req_t got);
      out_req_t want;
      if (owed_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h run_last %0b string_end %0b",
               got.out_byte, got.run_last, got.string_end);
        errors++;
      end else begin
        want = owed_bytes.pop_front();
        if (got.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
          errors++;
        end
        if (got.run_last !== want.run_last) begin
          $error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
          errors++;
        end
        if (got.string_end !== want.string_end) begin
          $error("string_end: expected %0b, actual %0b", want.string_end, got.string_end);
          errors++;
        end
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_req;

  sanitizer_mirror mirror;
  in_req_t         string_bytes [$];
  bit              scatter_ends;

  utf8_display_sanitizer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_req  (out_req)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("utf8_display_sanitizer_unit_tb NOT OK");
    $finish;
  end

  task automatic add_byte(input logic [7:0] b, input bit last);
    in_req_t r;
    r.in_byte = b;
    r.in_last = last;
    string_bytes.push_back(r);
  endtask

  task automatic push_code(input logic [20:0] cp, input int len, input int keep,
                           input bit end_str);
    logic [7:0] e [4];
    case (len)
      1: e[0] = {1'b0, cp[6:0]};
      2: begin
        e[0] = {3'b110, cp[10:6]};
        e[1] = {2'b10, cp[5:0]};
      end
      3: begin
        e[0] = {4'b1110, cp[15:12]};
        e[1] = {2'b10, cp[11:6]};
        e[2] = {2'b10, cp[5:0]};
      end
      default: begin
        e[0] = {5'b11110, cp[20:18]};
        e[1] = {2'b10, cp[17:12]};
        e[2] = {2'b10, cp[11:6]};
        e[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++)
      add_byte(e[i], (i == keep - 1) ? end_str : (scatter_ends && $urandom_range(0, 29) == 0));
  endtask

  task automatic build_random_strings(input int total);
    int          pick;
    int          len;
    bit          fin;
    logic [20:0] cp;
    while (string_bytes.size() < total) begin
      pick = $urandom_range(0, 99);
      fin  = ($urandom_range(0, 5) == 0);
      if (pick < 18) begin
        push_code(21'($urandom_range(0, 'h7f)), 1, 1, fin);
      end else if (pick < 32) begin
        push_code(21'($urandom_range('h80, 'h7ff)), 2, 2, fin);
      end else if (pick < 46) begin
        push_code(21'($urandom_range('h800, 'hffff)), 3, 3, fin);
      end else if (pick < 54) begin
        len = 3;
        case ($urandom_range(0, 4))
          0: begin
            cp  = 21'($urandom_range('h80, 'h9f));
            len = 2;
          end
          1: begin
            cp  = 21'h061c;
            len = 2;
          end
          2: cp = 21'($urandom_range('h200e, 'h200f));
          3: cp = 21'($urandom_range('h2028, 'h202e));
          default: cp = 21'($urandom_range('h2066, 'h2069));
        endcase
        push_code(cp, len, len, fin);
      end else if (pick < 66) begin
        push_code(21'($urandom_range('h10000, 'h10ffff)), 4, 4, fin);
      end else if (pick < 70) begin
        push_code(21'($urandom_range('h110000, 'h1fffff)), 4, 4, fin);
      end else if (pick < 74) begin
        push_code(21'($urandom_range('hd800, 'hdfff)), 3, 3, fin);
      end else if (pick < 80) begin
        len = $urandom_range(2, 4);
        cp  = 21'($urandom_range(0, (len == 2) ? 'h7f : (len == 3) ? 'h7ff : 'hffff));
        push_code(cp, len, len, fin);
      end else if (pick < 88) begin
        len = $urandom_range(2, 4);
        cp  = 21'((len == 2) ? $urandom_range('h80, 'h7ff) :
                  (len == 3) ? $urandom_range('h800, 'hffff) :
                               $urandom_range('h10000, 'h10ffff));
        push_code(cp, len, $urandom_range(1, len - 1), fin);
      end else begin
        add_byte(8'($urandom_range(0, 255)), fin);
      end
    end
  endtask

  task automatic send_req(input in_req_t r, input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    mirror.take_byte(r);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) mirror.match_output(out_req);
  end

  initial begin
    int took;
    int gap;
    took      = 0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (took == 150) gap = 120;
      else if ((took / 24) % 3 == 0) gap = 0;
      else gap = $urandom_range(0, 10);
      @(negedge clk);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      took++;
    end
  end

  initial begin
    mirror   = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;

    scatter_ends = 1'b0;
    add_byte(8'h00, 1'b0);
    add_byte(8'h7f, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hff, 1'b0);
    push_code(21'h80, 2, 2, 1'b0);
    push_code(21'h0, 2, 2, 1'b0);
    push_code(21'hd800, 3, 3, 1'b0);
    push_code(21'h200e, 3, 3, 1'b0);
    push_code(21'h110000, 4, 4, 1'b0);
    push_code(21'h1f600, 4, 4, 1'b1);
    push_code(21'h2000, 3, 1, 1'b0);
    add_byte(8'h41, 1'b0);
    push_code(21'h1f600, 4, 2, 1'b1);
    scatter_ends = 1'b1;
    build_random_strings(250);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (string_bytes[i]) send_req(string_bytes[i], (i % 40) < 10);
    @(negedge clk);
    in_valid <= 1'b0;

    while (mirror.owed_bytes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("utf8_display_sanitizer_unit_tb OK");
    end else begin
      $display("utf8_display_sanitizer_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
